// ----- src/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque: operation and status
// codes, default capacity and the per-cycle command that drives the cells.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned DataW       = 32;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cmd_t;

endpackage

// ----- src/cdq_cell.sv -----
// ----------------------------------------------------------------------------
// cdq_cell
// One slot of the deque chain. Holds one word and an occupied bit; shifts
// toward the rear on push front, toward the front on pop front, loads the
// pushed word when it is the first free slot on push rear, and frees itself
// when it is the last held slot on pop rear.
// ----------------------------------------------------------------------------
module cdq_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cdq_pkg::cmd_t                    cmd_i,
  input  logic signed [cdq_pkg::DataW-1:0] value_i,
  input  logic signed [cdq_pkg::DataW-1:0] left_data_i,
  input  logic                             left_occ_i,
  input  logic signed [cdq_pkg::DataW-1:0] right_data_i,
  input  logic                             right_occ_i,
  output logic signed [cdq_pkg::DataW-1:0] data_o,
  output logic                             occ_o,
  output logic signed [cdq_pkg::DataW-1:0] tail_tap_o
);
  import cdq_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic                    occ_q, occ_d;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    if (cmd_i.push_front) begin
      data_d = left_data_i;
      occ_d  = left_occ_i;
    end else if (cmd_i.push_rear) begin
      if (!occ_q && left_occ_i) begin
        data_d = value_i;
        occ_d  = 1'b1;
      end
    end else if (cmd_i.pop_front) begin
      data_d = right_data_i;
      occ_d  = right_occ_i;
    end else if (cmd_i.pop_rear) begin
      occ_d = occ_q & right_occ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign occ_o      = occ_q;
  assign tail_tap_o = (occ_q && !right_occ_i) ? data_q : '0;

endmodule

// ----- src/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque
// Fixed-capacity double-ended queue built as a chain of word cells with the
// front at cell zero. Push or pop at either end; one result per item.
// ----------------------------------------------------------------------------
// Result path: the accepted item is registered in pend_q and then in
// result_valid_o, the result strobe; the status follows through pend_status_q.
// Throughput: one item per cycle; busy stays low, as every operation is a
// single shift or load across the cell chain.
// Reset: asynchronous, active low; clears the counts, occupied bits, status
// and result flags, not the stored or end words. The receiver cannot stall.
// ----------------------------------------------------------------------------
module circular_deque #(
  parameter int unsigned CAPACITY = cdq_pkg::DefCapacity,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  cdq_pkg::kind_e                   kind_i,
  input  logic signed [cdq_pkg::DataW-1:0] value_i,
  output logic                             result_valid_o,
  output cdq_pkg::status_e                 status_o,
  output logic signed [cdq_pkg::DataW-1:0] head_value_o,
  output logic signed [cdq_pkg::DataW-1:0] tail_value_o,
  output logic                             empty_res_o,
  output logic [CntW-1:0]                  count_o
);
  import cdq_pkg::*;

  logic              accept;
  logic              full, empty;
  cmd_t              cmd;
  status_e           status_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pend_q;
  status_e           pend_status_q;

  logic signed [DataW-1:0] cell_data [CAPACITY];
  logic                    cell_occ  [CAPACITY];
  logic signed [DataW-1:0] cell_tap  [CAPACITY];
  logic signed [DataW-1:0] tail_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);

  always_comb begin
    cmd      = '0;
    status_d = ST_OK;
    count_d  = count_q;
    if (accept) begin
      unique case (kind_i)
        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            cmd.push_front = (kind_i == KIND_PUSH_FRONT);
            cmd.push_rear  = (kind_i == KIND_PUSH_REAR);
            count_d        = count_q + 1'b1;
          end
        end
        KIND_POP_FRONT, KIND_POP_REAR: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            cmd.pop_front = (kind_i == KIND_POP_FRONT);
            cmd.pop_rear  = (kind_i == KIND_POP_REAR);
            count_d       = count_q - 1'b1;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] left_data, right_data;
    logic                    left_occ, right_occ;

    if (i == 0) begin : g_first
      assign left_data = value_i;
      assign left_occ  = 1'b1;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
      assign left_occ  = cell_occ[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
      assign right_occ  = cell_occ[i+1];
    end

    cdq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .value_i     (value_i),
      .left_data_i (left_data),
      .left_occ_i  (left_occ),
      .right_data_i(right_data),
      .right_occ_i (right_occ),
      .data_o      (cell_data[i]),
      .occ_o       (cell_occ[i]),
      .tail_tap_o  (cell_tap[i])
    );
  end

  always_comb begin
    tail_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_word = tail_word | cell_tap[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      pend_q         <= 1'b0;
      pend_status_q  <= ST_OK;
      result_valid_o <= 1'b0;
      status_o       <= ST_OK;
      empty_res_o    <= 1'b1;
      count_o        <= '0;
    end else begin
      count_q        <= count_d;
      pend_q         <= accept;
      pend_status_q  <= status_d;
      result_valid_o <= pend_q;
      status_o       <= pend_status_q;
      empty_res_o    <= empty;
      count_o        <= count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    head_value_o <= cell_occ[0] ? cell_data[0] : '0;
    tail_value_o <= tail_word;
  end

endmodule

// ----- src/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the circular deque: result timing, empty flag against
// count and end words, count range, and error codes against the reported count.
// ----------------------------------------------------------------------------
module cdq_checker #(
  parameter int unsigned CAPACITY = cdq_pkg::DefCapacity,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             result_valid_o,
  input cdq_pkg::status_e                 status_o,
  input logic signed [cdq_pkg::DataW-1:0] head_value_o,
  input logic signed [cdq_pkg::DataW-1:0] tail_value_o,
  input logic                             empty_res_o,
  input logic [CntW-1:0]                  count_o
);
  import cdq_pkg::*;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 result_valid_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (empty_res_o == (count_o == '0)) &&
                       (!empty_res_o || (head_value_o == '0 && tail_value_o == '0)))
    else $error("empty flag, count or end words disagree");

  a_error_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o != ST_OVERFLOW  || count_o == CntW'(CAPACITY)) &&
                       (status_o != ST_UNDERFLOW || count_o == '0))
    else $error("error code does not match count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (count_o <= CntW'(CAPACITY)))
    else $error("count beyond capacity");

endmodule

bind circular_deque cdq_checker #(.CAPACITY(CAPACITY)) u_cdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .status_o      (status_o),
  .head_value_o  (head_value_o),
  .tail_value_o  (tail_value_o),
  .empty_res_o   (empty_res_o),
  .count_o       (count_o)
);
